[hdl/cst_pkg.sv]
`timescale 1ns / 1ps

package cst_pkg;

  // Field and register widths
  localparam int DEPTH_W  = 6;
  localparam int OFFSET_W = 24;
  localparam int VALUE_W  = 60;
  localparam int WIDE_W   = VALUE_W + 2;

  // Threshold accumulator: log3(2) in fixed point, 24 fraction bits
  localparam int ACC_FRAC_W = 24;
  localparam int ACC_W      = ACC_FRAC_W + DEPTH_W;
  localparam logic [ACC_W-1:0] THR_STEP = 30'd10585245;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_DEPTH_IN_USE = 1'b0;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } stat_t;

endpackage

[hdl/cst_regs.sv]
`timescale 1ns / 1ps

module cst_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cst_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cst_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cst_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [cst_pkg::DEPTH_W-1:0]      depth_cfg
);

  logic [cst_pkg::DEPTH_W-1:0] depth_r;
  logic [cst_pkg::DEPTH_W-1:0] depth_nxt;
  logic                        hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == cst_pkg::REG_DEPTH_IN_USE);

  // Take a write on the access phase of a transfer
  always_comb begin
    depth_nxt = depth_r;
    if (psel && penable && pwrite && hit) begin
      depth_nxt = pwdata[cst_pkg::DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= cst_pkg::DEPTH_RESET;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Read back; unmapped addresses return zero
  assign prdata    = hit ? cst_pkg::APB_DATA_W'(depth_r) : '0;
  assign depth_cfg = depth_r;

endmodule

[hdl/cst_ctrl.sv]
`timescale 1ns / 1ps

module cst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cst_pkg::stat_t stat,
  output cst_pkg::cmd_t  cmd
);

  cst_pkg::state_t state_r;
  cst_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  // Output register can take a result this cycle
  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cst_pkg::ST_RUN;
      end
      cst_pkg::ST_RUN: begin
        if (stat.done) state_nxt = slot_free ? cst_pkg::ST_IDLE : cst_pkg::ST_WAIT;
      end
      cst_pkg::ST_WAIT: begin
        if (slot_free) state_nxt = cst_pkg::ST_IDLE;
      end
      default: state_nxt = cst_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cst_pkg::ST_RUN: begin
        cmd.step    = !stat.done;
        cmd.publish = stat.done && slot_free;
      end
      cst_pkg::ST_WAIT: begin
        cmd.publish = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid: set on publish, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/cst_datapath.sv]
`timescale 1ns / 1ps

module cst_datapath #(
  parameter int MAX_DEPTH   = 61,
  parameter int OFFSET_BITS = 24
) (
  input  logic                            clk,
  input  cst_pkg::cmd_t                   cmd,
  output cst_pkg::stat_t                  stat,
  input  logic [cst_pkg::DEPTH_W-1:0]     depth_cfg,
  input  logic [cst_pkg::OFFSET_W-1:0]    in_start_offset,
  output logic                            out_survived,
  output logic [cst_pkg::DEPTH_W-1:0]     out_lifespan,
  output logic [cst_pkg::VALUE_W-1:0]     out_end_value,
  output logic [cst_pkg::DEPTH_W-1:0]     out_odd_steps
);

  localparam logic [cst_pkg::DEPTH_W-1:0] MaxDepth = cst_pkg::DEPTH_W'(MAX_DEPTH);

  logic [cst_pkg::VALUE_W-1:0] n_r, n_nxt;
  logic [cst_pkg::DEPTH_W-1:0] q_r, q_nxt;
  logic [cst_pkg::DEPTH_W-1:0] k_r, k_nxt;
  logic [cst_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [cst_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                        fail_r, fail_nxt;

  logic [cst_pkg::WIDE_W-1:0]  n_triple;
  logic [cst_pkg::VALUE_W-1:0] n_step;
  logic [cst_pkg::DEPTH_W-1:0] q_step;
  logic [cst_pkg::ACC_W-1:0]   acc_step;
  logic [cst_pkg::DEPTH_W-1:0] thr_step;

  // One shortcut map step: odd n -> (3n+1)/2, even n -> n/2
  assign n_triple = cst_pkg::WIDE_W'(n_r) + cst_pkg::WIDE_W'({n_r, 1'b0})
                  + cst_pkg::WIDE_W'(1);
  assign n_step   = n_r[0] ? n_triple[cst_pkg::VALUE_W:1]
                           : {1'b0, n_r[cst_pkg::VALUE_W-1:1]};
  assign q_step   = q_r + cst_pkg::DEPTH_W'(n_r[0]);

  // Threshold after step k is floor(k*log3(2)) + 1
  assign acc_step = acc_r + cst_pkg::THR_STEP;
  assign thr_step = acc_step[cst_pkg::ACC_W-1:cst_pkg::ACC_FRAC_W] + cst_pkg::DEPTH_W'(1);

  always_comb begin
    n_nxt     = n_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    depth_nxt = depth_r;
    acc_nxt   = acc_r;
    fail_nxt  = fail_r;
    if (cmd.load) begin
      n_nxt     = cst_pkg::VALUE_W'(in_start_offset[OFFSET_BITS-1:0]);
      q_nxt     = '0;
      k_nxt     = '0;
      acc_nxt   = '0;
      fail_nxt  = 1'b0;
      depth_nxt = (depth_cfg > MaxDepth) ? MaxDepth : depth_cfg;
    end else if (cmd.step) begin
      n_nxt    = n_step;
      q_nxt    = q_step;
      k_nxt    = k_r + cst_pkg::DEPTH_W'(1);
      acc_nxt  = acc_step;
      fail_nxt = (q_step < thr_step);
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    k_r     <= k_nxt;
    depth_r <= depth_nxt;
    acc_r   <= acc_nxt;
    fail_r  <= fail_nxt;
  end

  // Stop on a failed threshold or when the depth is reached
  assign stat.done = fail_r || (k_r == depth_r);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_survived  <= !fail_r;
      out_lifespan  <= fail_r ? (k_r - cst_pkg::DEPTH_W'(1)) : k_r;
      out_end_value <= n_r;
      out_odd_steps <= q_r;
    end
  end

endmodule

[hdl/collatz_stopping_time_sieve.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_start_offset
// out       output     out_valid / out_ready  out_survived, out_lifespan,
//                                             out_end_value, out_odd_steps
// cfg       input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An item goes through accept, then one map step per cycle for up to depth
// steps, then publish. The single step unit in the datapath takes one item
// at a time; an early threshold failure ends the stepping before depth.
// Reset is synchronous, active low, and sets depth to 61.
// A result held by out_ready low does not block the next accept; the
// following result waits until the output register frees.

module collatz_stopping_time_sieve #(
  parameter int MAX_DEPTH   = 61,
  parameter int OFFSET_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cst_pkg::OFFSET_W-1:0]    in_start_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_survived,
  output logic [cst_pkg::DEPTH_W-1:0]     out_lifespan,
  output logic [cst_pkg::VALUE_W-1:0]     out_end_value,
  output logic [cst_pkg::DEPTH_W-1:0]     out_odd_steps,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cst_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cst_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cst_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  cst_pkg::cmd_t               cmd;
  cst_pkg::stat_t              stat;
  logic [cst_pkg::DEPTH_W-1:0] depth_cfg;

  cst_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .depth_cfg (depth_cfg)
  );

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cst_datapath #(
    .MAX_DEPTH   (MAX_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .depth_cfg       (depth_cfg),
    .in_start_offset (in_start_offset),
    .out_survived    (out_survived),
    .out_lifespan    (out_lifespan),
    .out_end_value   (out_end_value),
    .out_odd_steps   (out_odd_steps)
  );

endmodule

[hdl/cst_checker.sv]
`timescale 1ns / 1ps

module cst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cst_pkg::DEPTH_W-1:0]     out_lifespan,
  input logic [cst_pkg::VALUE_W-1:0]     out_end_value,
  input logic [cst_pkg::DEPTH_W-1:0]     out_odd_steps
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_end_value))
    else $error("stalled result changed");

  // Busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // Odd count never exceeds the steps taken
  a_odd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_odd_steps} <= ({1'b0, out_lifespan} + 7'd1)))
    else $error("odd count above step count");

  // Drop results during reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind collatz_stopping_time_sieve cst_checker u_cst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_lifespan  (out_lifespan),
  .out_end_value (out_end_value),
  .out_odd_steps (out_odd_steps)
);
